// ===== design/tarms_pkg.sv =====
package tarms_pkg;

  // Field widths of the item ports.
  localparam int unsigned XW = 3;
  localparam int unsigned YW = 3;
  localparam int unsigned ZW = 2;
  localparam int unsigned LW = 3;
  localparam int unsigned DW = 3;

  // Default mesh size.
  localparam int unsigned MESH_X_DEF = 8;
  localparam int unsigned MESH_Y_DEF = 8;
  localparam int unsigned MESH_Z_DEF = 4;

  // Reset value of the layer count register.
  localparam logic [LW-1:0] LAYERS_RST = 3'd4;

  // Route decision codes.
  typedef enum logic [DW-1:0] {
    DEC_WEST_FIRST    = 3'd0,
    DEC_XYZ           = 3'd1,
    DEC_DOWNWARD      = 3'd2,
    DEC_SAME_NODE     = 3'd3,
    DEC_DST_THROTTLED = 3'd4,
    DEC_BLOCKED       = 3'd5
  } dec_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DST,
    ST_COL,
    ST_RECT,
    ST_EVAL1,
    ST_XP,
    ST_YP,
    ST_EVAL2,
    ST_DS,
    ST_DD,
    ST_EVAL3
  } state_t;

  // Which hit flag a map read in flight belongs to.
  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_DST,
    TAG_COL,
    TAG_RECT,
    TAG_XYZ,
    TAG_DOWN
  } tag_t;

  // One vertical run of cells, lo to hi inclusive; en low means empty.
  typedef struct packed {
    logic          en;
    logic [ZW-1:0] lo;
    logic [ZW-1:0] hi;
  } zscan_t;

  // A query after saturation, with its scan bounds.
  typedef struct packed {
    logic [XW-1:0] sx;
    logic [YW-1:0] sy;
    logic [ZW-1:0] sz;
    logic [XW-1:0] dx;
    logic [YW-1:0] dy;
    logic [ZW-1:0] dz;
    logic [XW-1:0] lox;
    logic [XW-1:0] hix;
    logic [YW-1:0] loy;
    logic [YW-1:0] hiy;
    logic          same;
    zscan_t        col;
    zscan_t        ds;
    zscan_t        dd;
  } query_t;

  // One item as handed to the sequencer.
  typedef struct packed {
    logic          query;
    logic          wr_ok;
    logic          wr_val;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [ZW-1:0] cz;
    query_t        q;
  } cmd_t;

  // Result strobe and decision.
  typedef struct packed {
    logic valid;
    dec_t decision;
  } result_t;

endpackage

// ===== design/throttle_aware_route_mode_select_unit.sv =====
// Channel | Ports                                           | Handshake
// input   | in_command, in_src_*, in_dst_*, in_cell_*,      | start && !busy
//         | in_throttled                                    |
// result  | out_decision                                    | out_valid, one cycle
// config  | cfg_wdata                                       | cfg_we
//
// A map write is taken with busy low; a same-node query answers in the next cycle.
// Other queries read one map cell per cycle: destination, column, rectangle, evaluate, then
// row and column of the XYZ path, evaluate, the two upward columns, evaluate; out_valid
// rises after the evaluate that decides, in the same cycle that busy falls.
// After reset the map is cleared one cell per cycle with busy high; configuration writes
// are taken meanwhile. The receiver cannot stall.
module throttle_aware_route_mode_select_unit
  import tarms_pkg::*;
#(
  parameter int unsigned MESH_X = MESH_X_DEF,
  parameter int unsigned MESH_Y = MESH_Y_DEF,
  parameter int unsigned MESH_Z = MESH_Z_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_command,
  input  logic [XW-1:0] in_src_x,
  input  logic [YW-1:0] in_src_y,
  input  logic [ZW-1:0] in_src_z,
  input  logic [XW-1:0] in_dst_x,
  input  logic [YW-1:0] in_dst_y,
  input  logic [ZW-1:0] in_dst_z,
  input  logic [XW-1:0] in_cell_x,
  input  logic [YW-1:0] in_cell_y,
  input  logic [ZW-1:0] in_cell_z,
  input  logic          in_throttled,
  output logic          out_valid,
  output logic [DW-1:0] out_decision,
  input  logic          cfg_we,
  input  logic [LW-1:0] cfg_wdata
);

  // Layers that can hold a written cell.
  localparam int unsigned ZCELLS = 1 << ZW;
  localparam int unsigned ZLIM   = (MESH_Z < ZCELLS) ? MESH_Z : ZCELLS;

  logic [LW-1:0] layers_r;
  logic [LW-1:0] lim, lim_m1, sz1, dz1;
  logic [XW-1:0] sx, dx;
  logic [YW-1:0] sy, dy;
  logic [ZW-1:0] sz, dz;
  cmd_t          cmd;
  result_t       res;

  // Layer count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layers_r <= LAYERS_RST;
    end else if (cfg_we) begin
      layers_r <= cfg_wdata;
    end
  end

  // Coordinates beyond the mesh saturate to its last index.
  assign sx = (32'(in_src_x) >= MESH_X) ? XW'(MESH_X - 1) : in_src_x;
  assign sy = (32'(in_src_y) >= MESH_Y) ? YW'(MESH_Y - 1) : in_src_y;
  assign sz = (32'(in_src_z) >= MESH_Z) ? ZW'(MESH_Z - 1) : in_src_z;
  assign dx = (32'(in_dst_x) >= MESH_X) ? XW'(MESH_X - 1) : in_dst_x;
  assign dy = (32'(in_dst_y) >= MESH_Y) ? YW'(MESH_Y - 1) : in_dst_y;
  assign dz = (32'(in_dst_z) >= MESH_Z) ? ZW'(MESH_Z - 1) : in_dst_z;

  // Upward columns end below the clamped layer count.
  assign lim    = (layers_r > LW'(ZLIM)) ? LW'(ZLIM) : layers_r;
  assign lim_m1 = lim - LW'(1);
  assign sz1    = {1'b0, sz} + LW'(1);
  assign dz1    = {1'b0, dz} + LW'(1);

  // Build the item for the sequencer, with the scan bounds of a query.
  always_comb begin
    cmd.query  = in_command;
    cmd.wr_ok  = (32'(in_cell_x) < MESH_X) && (32'(in_cell_y) < MESH_Y) &&
                 (32'(in_cell_z) < MESH_Z);
    cmd.wr_val = in_throttled;
    cmd.cx     = in_cell_x;
    cmd.cy     = in_cell_y;
    cmd.cz     = in_cell_z;
    cmd.q.sx   = sx;
    cmd.q.sy   = sy;
    cmd.q.sz   = sz;
    cmd.q.dx   = dx;
    cmd.q.dy   = dy;
    cmd.q.dz   = dz;
    cmd.q.lox  = (sx < dx) ? sx : dx;
    cmd.q.hix  = (sx < dx) ? dx : sx;
    cmd.q.loy  = (sy < dy) ? sy : dy;
    cmd.q.hiy  = (sy < dy) ? dy : sy;
    cmd.q.same = (sx == dx) && (sy == dy) && (sz == dz);
    // Destination column between source and destination layers.
    if (dz > sz) begin
      cmd.q.col.en = 1'b1;
      cmd.q.col.lo = sz1[ZW-1:0];
      cmd.q.col.hi = dz;
    end else if (dz < sz) begin
      cmd.q.col.en = 1'b1;
      cmd.q.col.lo = dz;
      cmd.q.col.hi = sz - ZW'(1);
    end else begin
      cmd.q.col.en = 1'b0;
      cmd.q.col.lo = sz;
      cmd.q.col.hi = sz;
    end
    // Column above the source.
    cmd.q.ds.en = (sz1 < lim);
    cmd.q.ds.lo = cmd.q.ds.en ? sz1[ZW-1:0] : sz;
    cmd.q.ds.hi = cmd.q.ds.en ? lim_m1[ZW-1:0] : sz;
    // Column above the destination.
    cmd.q.dd.en = (dz1 < lim);
    cmd.q.dd.lo = cmd.q.dd.en ? dz1[ZW-1:0] : dz;
    cmd.q.dd.hi = cmd.q.dd.en ? lim_m1[ZW-1:0] : dz;
  end

  tarms_seq #(
    .MESH_X(MESH_X),
    .MESH_Y(MESH_Y),
    .MESH_Z(MESH_Z)
  ) u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .res  (res)
  );

  assign out_valid    = res.valid;
  assign out_decision = res.decision;

endmodule

// ===== design/tarms_ram.sv =====
module tarms_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tarms_seq.sv =====
module tarms_seq
  import tarms_pkg::*;
#(
  parameter int unsigned MESH_X = MESH_X_DEF,
  parameter int unsigned MESH_Y = MESH_Y_DEF,
  parameter int unsigned MESH_Z = MESH_Z_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output result_t res
);

  localparam int unsigned DEPTH = MESH_X * MESH_Y * MESH_Z;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Map address of one cell.
  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y,
                                               input logic [ZW-1:0] z);
    logic [31:0] a;
    a = (32'(x) * 32'(MESH_Y) + 32'(y)) * 32'(MESH_Z) + 32'(z);
    return a[AW-1:0];
  endfunction

  state_t        state_r, state_nxt;
  query_t        q_r, q_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [ZW-1:0] z_r, z_nxt;
  tag_t          tag_r, tag_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          res_valid_r, res_valid_nxt;
  dec_t          res_dec_r, res_dec_nxt;
  logic          dst_hit_r, col_hit_r, rect_hit_r, xyz_hit_r, down_hit_r;
  logic          dst_now, col_now, rect_now, xyz_now, down_now;

  logic [XW-1:0] rd_x;
  logic [YW-1:0] rd_y;
  logic [ZW-1:0] rd_z;
  logic [AW-1:0] raddr;
  logic          rdata;
  logic          map_we;
  logic [AW-1:0] waddr;
  logic          wdata;

  logic accept, qry_acc;
  logic clr_last, col_last, rect_last, xp_last, yp_last, ds_last, dd_last;

  assign accept  = start && (state_r == ST_IDLE);
  assign qry_acc = accept && cmd.query;
  assign busy    = (state_r != ST_IDLE);

  // End of each scan run.
  assign clr_last  = (clr_r == AW'(DEPTH - 1));
  assign col_last  = (z_r == q_r.col.hi);
  assign rect_last = (x_r == q_r.hix) && (y_r == q_r.hiy);
  assign xp_last   = (x_r == q_r.hix);
  assign yp_last   = (y_r == q_r.hiy);
  assign ds_last   = (z_r == q_r.ds.hi);
  assign dd_last   = (z_r == q_r.dd.hi);

  // Hit flags including the read that lands this cycle.
  assign dst_now  = dst_hit_r  || ((tag_r == TAG_DST)  && rdata);
  assign col_now  = col_hit_r  || ((tag_r == TAG_COL)  && rdata);
  assign rect_now = rect_hit_r || ((tag_r == TAG_RECT) && rdata);
  assign xyz_now  = xyz_hit_r  || ((tag_r == TAG_XYZ)  && rdata);
  assign down_now = down_hit_r || ((tag_r == TAG_DOWN) && rdata);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (qry_acc && !cmd.q.same) state_nxt = ST_DST;
      ST_DST:   state_nxt = ST_COL;
      ST_COL:   if (col_last) state_nxt = ST_RECT;
      ST_RECT:  if (rect_last) state_nxt = ST_EVAL1;
      ST_EVAL1: begin
        if (dst_now || !(rect_now || col_now)) begin
          state_nxt = ST_IDLE;
        end else if (col_now) begin
          state_nxt = ST_DS;
        end else begin
          state_nxt = ST_XP;
        end
      end
      ST_XP:    if (xp_last) state_nxt = ST_YP;
      ST_YP:    if (yp_last) state_nxt = ST_EVAL2;
      ST_EVAL2: state_nxt = (xyz_now || col_now) ? ST_DS : ST_IDLE;
      ST_DS:    if (ds_last) state_nxt = ST_DD;
      ST_DD:    if (dd_last) state_nxt = ST_EVAL3;
      ST_EVAL3: state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Counters, map reads and results.
  always_comb begin
    q_nxt         = q_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    clr_nxt       = clr_r;
    tag_nxt       = TAG_NONE;
    rd_x          = q_r.dx;
    rd_y          = q_r.dy;
    rd_z          = q_r.dz;
    res_valid_nxt = 1'b0;
    res_dec_nxt   = res_dec_r;
    map_we        = 1'b0;
    waddr         = cell_addr(cmd.cx, cmd.cy, cmd.cz);
    wdata         = cmd.wr_val;
    unique case (state_r)
      ST_CLEAR: begin
        map_we  = 1'b1;
        waddr   = clr_r;
        wdata   = 1'b0;
        clr_nxt = clr_r + AW'(1);
      end
      ST_IDLE: begin
        map_we = accept && !cmd.query && cmd.wr_ok;
        if (qry_acc) begin
          q_nxt = cmd.q;
          z_nxt = cmd.q.col.lo;
          if (cmd.q.same) begin
            res_valid_nxt = 1'b1;
            res_dec_nxt   = DEC_SAME_NODE;
          end
        end
      end
      ST_DST: begin
        tag_nxt = TAG_DST;
      end
      ST_COL: begin
        rd_z    = z_r;
        tag_nxt = q_r.col.en ? TAG_COL : TAG_NONE;
        if (col_last) begin
          x_nxt = q_r.lox;
          y_nxt = q_r.loy;
        end else begin
          z_nxt = z_r + ZW'(1);
        end
      end
      ST_RECT: begin
        rd_x    = x_r;
        rd_y    = y_r;
        rd_z    = q_r.sz;
        tag_nxt = TAG_RECT;
        if (x_r == q_r.hix) begin
          x_nxt = q_r.lox;
          if (y_r != q_r.hiy) y_nxt = y_r + YW'(1);
        end else begin
          x_nxt = x_r + XW'(1);
        end
      end
      ST_EVAL1: begin
        x_nxt = q_r.lox;
        z_nxt = q_r.ds.lo;
        if (dst_now) begin
          res_valid_nxt = 1'b1;
          res_dec_nxt   = DEC_DST_THROTTLED;
        end else if (!(rect_now || col_now)) begin
          res_valid_nxt = 1'b1;
          res_dec_nxt   = DEC_WEST_FIRST;
        end
      end
      ST_XP: begin
        rd_x    = x_r;
        rd_y    = q_r.sy;
        rd_z    = q_r.sz;
        tag_nxt = (x_r != q_r.sx) ? TAG_XYZ : TAG_NONE;
        if (xp_last) begin
          y_nxt = q_r.loy;
        end else begin
          x_nxt = x_r + XW'(1);
        end
      end
      ST_YP: begin
        rd_y    = y_r;
        rd_z    = q_r.sz;
        tag_nxt = (y_r != q_r.sy) ? TAG_XYZ : TAG_NONE;
        if (!yp_last) y_nxt = y_r + YW'(1);
      end
      ST_EVAL2: begin
        z_nxt = q_r.ds.lo;
        if (!(xyz_now || col_now)) begin
          res_valid_nxt = 1'b1;
          res_dec_nxt   = DEC_XYZ;
        end
      end
      ST_DS: begin
        rd_x    = q_r.sx;
        rd_y    = q_r.sy;
        rd_z    = z_r;
        tag_nxt = q_r.ds.en ? TAG_DOWN : TAG_NONE;
        z_nxt   = ds_last ? q_r.dd.lo : z_r + ZW'(1);
      end
      ST_DD: begin
        rd_z    = z_r;
        tag_nxt = q_r.dd.en ? TAG_DOWN : TAG_NONE;
        if (!dd_last) z_nxt = z_r + ZW'(1);
      end
      ST_EVAL3: begin
        res_valid_nxt = 1'b1;
        res_dec_nxt   = down_now ? DEC_BLOCKED : DEC_DOWNWARD;
      end
      default: begin
        tag_nxt = TAG_NONE;
      end
    endcase
  end

  // The single address unit feeds the one read port.
  assign raddr = cell_addr(rd_x, rd_y, rd_z);

  tarms_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      tag_r       <= TAG_NONE;
      clr_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tag_r       <= tag_nxt;
      clr_r       <= clr_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Query, counters and hit flags; hits clear when a query is taken.
  always_ff @(posedge clk) begin
    q_r       <= q_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    z_r       <= z_nxt;
    res_dec_r <= res_dec_nxt;
    if (qry_acc) begin
      dst_hit_r  <= 1'b0;
      col_hit_r  <= 1'b0;
      rect_hit_r <= 1'b0;
      xyz_hit_r  <= 1'b0;
      down_hit_r <= 1'b0;
    end else begin
      dst_hit_r  <= dst_now;
      col_hit_r  <= col_now;
      rect_hit_r <= rect_now;
      xyz_hit_r  <= xyz_now;
      down_hit_r <= down_now;
    end
  end

  assign res.valid    = res_valid_r;
  assign res.decision = res_dec_r;

  // The map is written only at idle or during the clearing pass.
  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    map_we |-> (state_r == ST_IDLE || state_r == ST_CLEAR))
    else $error("map written during a query scan");

  // A result follows an evaluation step or an idle accept only.
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> ($past(state_r) == ST_IDLE || $past(state_r) == ST_EVAL1 ||
                     $past(state_r) == ST_EVAL2 || $past(state_r) == ST_EVAL3))
    else $error("result without an evaluation step");

  // A read in flight was issued by a scan step.
  a_tag_src: assert property (@(posedge clk) disable iff (!rst_n)
    (tag_r != TAG_NONE) |-> ($past(state_r) != ST_IDLE && $past(state_r) != ST_CLEAR))
    else $error("map read tagged outside a scan");

  // The rectangle walk stays inside its bounds.
  a_rect_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RECT) |-> (x_r >= q_r.lox && x_r <= q_r.hix &&
                              y_r >= q_r.loy && y_r <= q_r.hiy))
    else $error("rectangle walk out of bounds");

endmodule
